>>> rtl/dh_modular_exponentiation_defines.svh
// Assertion macros for the modular exponentiation block
`ifndef DH_MODULAR_EXPONENTIATION_DEFINES_SVH
`define DH_MODULAR_EXPONENTIATION_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DHME_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define DHME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/dhme_pkg.sv
// Shared types and codes for the modular exponentiation block
`timescale 1ns / 1ps

package dhme_pkg;

   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODULUS         = 2'd0,
      CSR_GENERATOR       = 2'd1,
      CSR_SECRET_EXPONENT = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_PUBLIC_VALUE = 1'b0,
      OP_SHARED_KEY   = 1'b1
   } operation_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_SQUARE = 5'b00100,
      ST_MULT   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;       // latch transaction operands
      logic red_step;   // one step of base reduction
      logic red_last;   // final reduction step, seed accumulator
      logic mul_step;   // one step of modular product
      logic mul_last;   // final product step, write accumulator
      logic sel_base;   // multiplicand is the reduced base
      logic exp_shift;  // move to next exponent bit
      logic out_load;   // load result register
   } command_type;

   typedef struct packed {
      logic mod_small;  // modulus below two
      logic exp_msb;    // current exponent bit
   } status_type;

endpackage

>>> rtl/dh_modular_exponentiation.sv
// Top level of the Diffie-Hellman modular exponentiation block
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_operation, req_peer_value
//   rsp_     out        rsp_valid/rsp_stall  rsp_key_value
//   csr_     in         csr_write_enable     csr_index, csr_write_data
//
// One transaction at a time: base reduction, then per exponent bit a square
// and, for a set bit, a multiply, each on the shared shift-subtract unit,
// plus the hand-off of the request and of the result.
// A modulus below two skips the arithmetic and returns zero.
// Synchronous reset restores modulus 2, generator 0, exponent 0.
// A new request is taken while the previous result waits under rsp_stall.
`timescale 1ns / 1ps
`include "dh_modular_exponentiation_defines.svh"

module dh_modular_exponentiation #(
   parameter int VALUE_BITS = 31
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [dhme_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [VALUE_BITS-1:0]               csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [VALUE_BITS-1:0]               req_peer_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [VALUE_BITS-1:0]               rsp_key_value
);
   import dhme_pkg::*;

   command_type cmd;
   status_type  status;

   dhme_ctrl #(
      .VALUE_BITS(VALUE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dhme_datapath #(
      .VALUE_BITS(VALUE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_operation    (req_operation),
      .req_peer_value   (req_peer_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_key_value    (rsp_key_value)
   );

   // accepted request makes the block busy
   `DHME_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "request accepted but block not busy")
   // result load raises valid
   `DHME_ASSERT_NEXT(a_valid_after_load, clock, reset, cmd.out_load, rsp_valid, "result loaded but rsp_valid low")
   // result taken with no reload drops valid
   `DHME_ASSERT_NEXT(a_drop_after_take, clock, reset, rsp_valid && !rsp_stall && !cmd.out_load, !rsp_valid, "result delivered twice")
   // controller never loads a result over one still waiting
   `DHME_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.out_load && rsp_valid, !rsp_stall, "result overwritten while stalled")

endmodule

>>> rtl/dhme_datapath.sv
// Datapath: configuration, operand registers and shared shift-subtract unit
`timescale 1ns / 1ps

module dhme_datapath #(
   parameter int VALUE_BITS = 31
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [dhme_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [VALUE_BITS-1:0]                   csr_write_data,
   input  logic                                    req_operation,
   input  logic [VALUE_BITS-1:0]                   req_peer_value,
   input  dhme_pkg::command_type                   cmd,
   output dhme_pkg::status_type                    status,
   output logic [VALUE_BITS-1:0]                   rsp_key_value
);
   import dhme_pkg::*;

   logic [VALUE_BITS-1:0] modulus_ff, generator_ff, secret_ff;
   logic [VALUE_BITS-1:0] base_ff, base_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [VALUE_BITS-1:0] prod_ff, prod_in;
   logic [VALUE_BITS-1:0] mult_ff, mult_in;
   logic [VALUE_BITS-1:0] exp_ff, exp_in;
   logic [VALUE_BITS-1:0] key_ff, key_in;

   logic [VALUE_BITS:0]   red_t, red_m, red_next;
   logic [VALUE_BITS-1:0] mul_a;
   logic [VALUE_BITS+1:0] mul_s, mul_m1, mul_m2, mul_next;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= VALUE_BITS'(2);
         generator_ff <= '0;
         secret_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODULUS:         modulus_ff   <= csr_write_data;
            CSR_GENERATOR:       generator_ff <= csr_write_data;
            CSR_SECRET_EXPONENT: secret_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // restoring reduction: shift one base bit into the remainder
   assign red_t    = {prod_ff, mult_ff[VALUE_BITS-1]};
   assign red_m    = {1'b0, modulus_ff};
   assign red_next = (red_t >= red_m) ? (red_t - red_m) : red_t;

   // double-and-add product step: 2p + a*bit is below 3m
   assign mul_a    = cmd.sel_base ? base_ff : acc_ff;
   assign mul_m1   = {2'b00, modulus_ff};
   assign mul_m2   = {1'b0, modulus_ff, 1'b0};
   assign mul_s    = {1'b0, prod_ff, 1'b0}
                     + (mult_ff[VALUE_BITS-1] ? {2'b00, mul_a} : '0);
   assign mul_next = (mul_s >= mul_m2) ? (mul_s - mul_m2) :
                     (mul_s >= mul_m1) ? (mul_s - mul_m1) : mul_s;

   always_comb begin
      base_in = base_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      mult_in = mult_ff;
      exp_in  = exp_ff;
      key_in  = key_ff;
      if (cmd.load) begin
         mult_in = (req_operation == OP_SHARED_KEY) ? req_peer_value : generator_ff;
         prod_in = '0;
         exp_in  = secret_ff;
      end else if (cmd.red_last) begin
         base_in = red_next[VALUE_BITS-1:0];
         acc_in  = VALUE_BITS'(1);
         mult_in = VALUE_BITS'(1);
         prod_in = '0;
      end else if (cmd.red_step) begin
         prod_in = red_next[VALUE_BITS-1:0];
         mult_in = {mult_ff[VALUE_BITS-2:0], 1'b0};
      end else if (cmd.mul_last) begin
         acc_in  = mul_next[VALUE_BITS-1:0];
         mult_in = mul_next[VALUE_BITS-1:0];
         prod_in = '0;
      end else if (cmd.mul_step) begin
         prod_in = mul_next[VALUE_BITS-1:0];
         mult_in = {mult_ff[VALUE_BITS-2:0], 1'b0};
      end
      if (cmd.exp_shift) begin
         exp_in = {exp_ff[VALUE_BITS-2:0], 1'b0};
      end
      if (cmd.out_load) begin
         key_in = status.mod_small ? '0 : acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      mult_ff <= mult_in;
      exp_ff  <= exp_in;
      key_ff  <= key_in;
   end

   assign status.mod_small = (modulus_ff[VALUE_BITS-1:1] == '0);
   assign status.exp_msb   = exp_ff[VALUE_BITS-1];
   assign rsp_key_value    = key_ff;

endmodule

>>> rtl/dhme_ctrl.sv
// Controller: sequences reduction, squares and multiplies per exponent bit
`timescale 1ns / 1ps

module dhme_ctrl #(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  dhme_pkg::status_type  status,
   output dhme_pkg::command_type cmd
);
   import dhme_pkg::*;

   localparam int CNT_BITS = $clog2(VALUE_BITS);
   localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(VALUE_BITS - 1);

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] step_ff, step_in;
   logic [CNT_BITS-1:0] bit_ff, bit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = status.mod_small ? ST_FINISH : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (step_ff == LAST) begin
               cmd.red_last = 1'b1;
               step_in      = '0;
               bit_in       = '0;
               state_in     = ST_SQUARE;
            end else begin
               cmd.red_step = 1'b1;
               step_in      = step_ff + 1'b1;
            end
         end
         ST_SQUARE: begin
            if (step_ff == LAST) begin
               cmd.mul_last = 1'b1;
               step_in      = '0;
               if (status.exp_msb) begin
                  state_in = ST_MULT;
               end else begin
                  cmd.exp_shift = 1'b1;
                  bit_in        = bit_ff + 1'b1;
                  if (bit_ff == LAST) state_in = ST_FINISH;
               end
            end else begin
               cmd.mul_step = 1'b1;
               step_in      = step_ff + 1'b1;
            end
         end
         ST_MULT: begin
            cmd.sel_base = 1'b1;
            if (step_ff == LAST) begin
               cmd.mul_last  = 1'b1;
               cmd.exp_shift = 1'b1;
               step_in       = '0;
               bit_in        = bit_ff + 1'b1;
               state_in      = (bit_ff == LAST) ? ST_FINISH : ST_SQUARE;
            end else begin
               cmd.mul_step = 1'b1;
               step_in      = step_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> bench/tb_dh_modular_exponentiation.sv
// Self-checking bench for the modular exponentiation block: directed table, then random phases
`timescale 1ns / 1ps

module tb_dh_modular_exponentiation;
   import dhme_pkg::*;

   localparam int VB           = 31;
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int TAIL_CYCLES  = 2100;   // a little over the worst-case latency
   localparam int NUM_DIRECTED = 23;
   localparam int NUM_PHASES   = 8;
   localparam int PHASE_ITEMS  = 34;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam logic [VB-1:0] ALL_ONES = {VB{1'b1}};

   typedef struct packed {
      bit            load_cfg;
      logic [VB-1:0] modulus;
      logic [VB-1:0] generator;
      logic [VB-1:0] exponent;
      bit            poke_unused;
      operation_type op;
      logic [VB-1:0] peer;
      bit            known;
      logic [VB-1:0] want;
   } directed_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_MODULUS;
   logic [VB-1:0]             csr_write_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_operation = OP_PUBLIC_VALUE;
   logic [VB-1:0]             req_peer_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [VB-1:0]             rsp_key_value;

   // shadow of the block's registers, as after reset
   logic [VB-1:0] cfg_modulus   = 31'd2;
   logic [VB-1:0] cfg_generator = '0;
   logic [VB-1:0] cfg_exponent  = '0;

   logic [VB-1:0] key_expected[$];
   logic [VB-1:0] want_key;
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            sender_idle_pct = 0;
   int            receiver_stall_pct = 0;

   directed_row_type directed[NUM_DIRECTED] = '{
      // register values after reset
      '{0, 0, 0, 0, 0, OP_PUBLIC_VALUE, 0, 1, 1},
      '{0, 0, 0, 0, 0, OP_SHARED_KEY, ALL_ONES, 1, 1},
      // degenerate modulus reduces everything to zero
      '{1, 0, 5, 3, 0, OP_PUBLIC_VALUE, 0, 1, 0},
      '{0, 0, 0, 0, 0, OP_SHARED_KEY, 7, 1, 0},
      '{1, 1, 5, 3, 0, OP_PUBLIC_VALUE, 0, 1, 0},
      '{0, 0, 0, 0, 0, OP_SHARED_KEY, ALL_ONES, 1, 0},
      // zero base, non-zero exponent, then a base of one
      '{1, ALL_ONES, 0, 5, 0, OP_PUBLIC_VALUE, 0, 1, 0},
      '{0, 0, 0, 0, 0, OP_SHARED_KEY, 0, 1, 0},
      '{0, 0, 0, 0, 0, OP_SHARED_KEY, ALL_ONES, 1, 0},
      '{0, 0, 0, 0, 0, OP_SHARED_KEY, 1, 1, 1},
      // zero exponent, including zero to the zero
      '{1, ALL_ONES, 0, 0, 0, OP_PUBLIC_VALUE, 0, 1, 1},
      '{0, 0, 0, 0, 0, OP_SHARED_KEY, 12345, 1, 1},
      // widest exponent; -1 to an odd power stays -1
      '{1, ALL_ONES, 7, ALL_ONES, 0, OP_PUBLIC_VALUE, 0, 0, 0},
      '{0, 0, 0, 0, 0, OP_SHARED_KEY, ALL_ONES - 1'b1, 1, ALL_ONES - 1'b1},
      '{0, 0, 0, 0, 0, OP_SHARED_KEY, ALL_ONES, 1, 0},
      // textbook exchange, p = 23, g = 5, a = 6
      '{1, 23, 5, 6, 0, OP_PUBLIC_VALUE, 0, 1, 8},
      '{0, 0, 0, 0, 0, OP_SHARED_KEY, 19, 1, 2},
      '{0, 0, 0, 0, 0, OP_SHARED_KEY, 100, 0, 0},
      // write to an unmapped index must leave the registers alone
      '{1, 23, 5, 6, 1, OP_PUBLIC_VALUE, 0, 1, 8},
      '{1, 1000000007, ALL_ONES, 1, 0, OP_PUBLIC_VALUE, 0, 0, 0},
      '{0, 0, 0, 0, 0, OP_SHARED_KEY, ALL_ONES, 0, 0},
      '{1, 2, 1, 1, 0, OP_PUBLIC_VALUE, 0, 1, 1},
      '{1, ALL_ONES - 1'b1, 3, ALL_ONES, 0, OP_SHARED_KEY, 31'h4000_0000, 0, 0}
   };

   dh_modular_exponentiation #(
      .VALUE_BITS(VB)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_peer_value  (req_peer_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_value   (rsp_key_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // exact square-and-multiply over the full exponent width
   function automatic logic [VB-1:0] predict_key(operation_type op, logic [VB-1:0] peer);
      logic [63:0] m;
      logic [63:0] b;
      logic [63:0] acc;
      int          i;
      if (cfg_modulus < 2)
         return '0;
      m   = 64'(cfg_modulus);
      b   = 64'((op == OP_SHARED_KEY) ? peer : cfg_generator) % m;
      acc = 64'd1;
      for (i = VB - 1; i >= 0; i--) begin
         acc = (acc * acc) % m;
         if (cfg_exponent[i])
            acc = (acc * b) % m;
      end
      return acc[VB-1:0];
   endfunction

   task automatic sender_gap();
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // valid is left high on return; the caller lowers it if a gap follows
   task automatic push_request(operation_type op, logic [VB-1:0] peer, bit known,
                               logic [VB-1:0] want);
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_peer_value <= peer;
      do
         @(posedge clock);
      while (req_stall);
      key_expected.push_back(known ? want : predict_key(op, peer));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (key_expected.size() != 0);
   endtask

   task automatic apply_config(logic [VB-1:0] modv, logic [VB-1:0] genv,
                               logic [VB-1:0] expv, bit poke, logic [VB-1:0] junk);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_MODULUS;
      csr_write_data   <= modv;
      @(posedge clock);
      csr_index        <= CSR_GENERATOR;
      csr_write_data   <= genv;
      @(posedge clock);
      csr_index        <= CSR_SECRET_EXPONENT;
      csr_write_data   <= expv;
      @(posedge clock);
      if (poke) begin
         csr_index      <= CSR_UNUSED;
         csr_write_data <= junk;
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      cfg_modulus   = modv;
      cfg_generator = genv;
      cfg_exponent  = expv;
   endtask

   // result checker and receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (key_expected.size() == 0) begin
            $display("%0t: key_value %0d with no transaction outstanding",
                     $time, rsp_key_value);
            mismatch_count++;
         end else begin
            want_key = key_expected.pop_front();
            if (rsp_key_value !== want_key) begin
               $display("%0t: key_value mismatch, expected %0d, actual %0d",
                        $time, want_key, rsp_key_value);
               mismatch_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d transactions outstanding", $time, key_expected.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int            row;
      int            phase;
      int            item;
      logic [VB-1:0] modv;
      logic [VB-1:0] genv;
      logic [VB-1:0] expv;
      logic [VB-1:0] peer;
      operation_type op;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < NUM_DIRECTED; row++) begin
         if (directed[row].load_cfg) begin
            wait_drained();
            apply_config(directed[row].modulus, directed[row].generator,
                         directed[row].exponent, directed[row].poke_unused, ALL_ONES);
         end
         push_request(directed[row].op, directed[row].peer, directed[row].known,
                      directed[row].want);
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_drained();
         case ($urandom_range(9))
            0:       modv = VB'($urandom_range(1));
            1, 2:    modv = ALL_ONES;
            3, 4:    modv = VB'($urandom_range(200, 2));
            default: modv = VB'($urandom());
         endcase
         genv = VB'($urandom()) >> $urandom_range(30);
         case ($urandom_range(7))
            0:       expv = '0;
            1:       expv = ALL_ONES;
            2:       expv = VB'($urandom_range(15, 1));
            default: expv = VB'($urandom());
         endcase
         apply_config(modv, genv, expv, ($urandom_range(3) == 0), VB'($urandom()));

         case (phase % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 69;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 69;
            end
            default: begin
               sender_idle_pct    = 35;
               receiver_stall_pct = 35;
            end
         endcase

         for (item = 0; item < PHASE_ITEMS; item++) begin
            op = operation_type'($urandom_range(1));
            case ($urandom_range(5))
               0:       peer = '0;
               1:       peer = ALL_ONES;
               2:       peer = VB'($urandom_range(64));
               3:       peer = cfg_modulus + VB'($urandom_range(64));
               default: peer = VB'($urandom());
            endcase
            // now and then hold off until the block has handed back everything
            if ($urandom_range(24) == 0)
               wait_drained();
            else
               sender_gap();
            push_request(op, peer, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && key_expected.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
